FILE: hdl/gdad_pkg.sv
// Package for the Gregorian date adder: widths, date and control types,
// the sequencer states and the month length function.
// It has no dependencies and is compiled first.
`default_nettype none

package gdad_pkg;

  localparam int DAYS_BITS = 12;

  localparam logic [15:0] YEAR_TOP     = 16'hFFFF;
  localparam logic [3:0]  MONTH_FIRST  = 4'd1;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;
  localparam logic [4:0]  DAY_FIRST    = 5'd1;
  localparam logic [4:0]  DAYS_SHORT   = 5'd30;
  localparam logic [4:0]  DAYS_FEB_LY  = 5'd29;
  localparam logic [4:0]  DAYS_FEB     = 5'd28;
  localparam logic [4:0]  DAYS_LONG    = 5'd31;
  localparam logic [6:0]  CENTURY_LAST = 7'd99;
  localparam logic [7:0]  CENTURY      = 8'd100;

  // floor(y / 100) is (y * DIV100_MUL) >> DIV100_SHIFT, low by at most one.
  localparam logic [15:0] DIV100_MUL   = 16'd41943;
  localparam int          DIV100_SHIFT = 22;

  typedef struct packed {
    logic [6:0] yr100;
    logic [1:0] cent;
  } split_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [6:0]  yr100;
    logic [1:0]  cent;
  } date_t;

  typedef struct packed {
    logic [4:0] mlen;
    logic       at_end;
    date_t      next;
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } state_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: len = DAYS_SHORT;
      4'd2: len = leap ? DAYS_FEB_LY : DAYS_FEB;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_LONG;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gdad_ysplit.sv
// Splits a year into its value modulo 100 and its century modulo 4.
// Pipelined reciprocal multiply, remainder and fix-up; uses gdad_pkg.
`default_nettype none

module gdad_ysplit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [15:0]     year,
  output logic                 done,
  output gdad_pkg::split_t     res
);

  logic [2:0]       v_r;
  logic [15:0]      year_r;
  logic [31:0]      prod_r;
  logic [7:0]       rem_r;
  logic [1:0]       q_r;
  gdad_pkg::split_t res_r;

  logic [31:0] prod_w;
  logic [9:0]  q_w;
  logic [16:0] qx_w;
  logic [16:0] rem_w;

  assign prod_w = 32'(year) * 32'(gdad_pkg::DIV100_MUL);
  assign q_w    = prod_r[gdad_pkg::DIV100_SHIFT +: 10];
  assign qx_w   = 17'(q_w) * 17'(gdad_pkg::CENTURY);
  assign rem_w  = {1'b0, year_r} - qx_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      year_r <= year;
      prod_r <= prod_w;
    end
    if (v_r[0]) begin
      rem_r <= rem_w[7:0];
      q_r   <= q_w[1:0];
    end
    if (v_r[1]) begin
      if (rem_r >= gdad_pkg::CENTURY) begin
        res_r.yr100 <= 7'(rem_r - gdad_pkg::CENTURY);
        res_r.cent  <= q_r + 2'd1;
      end else begin
        res_r.yr100 <= rem_r[6:0];
        res_r.cent  <= q_r;
      end
    end
  end

  assign done = v_r[2];
  assign res  = res_r;

endmodule

`default_nettype wire

FILE: hdl/gdad_step.sv
// Shared date unit: gives the length of the current month and the date one day
// later (or at_end), used for the validity check and every step; uses gdad_pkg.
`default_nettype none

module gdad_step (
  input  wire gdad_pkg::date_t cur,
  output gdad_pkg::step_t      res
);

  logic       leap;
  logic [4:0] mlen;

  assign leap = ((cur.year[1:0] == 2'd0) && (cur.yr100 != 7'd0)) ||
                ((cur.yr100 == 7'd0) && (cur.cent == 2'd0));
  assign mlen = gdad_pkg::month_len(cur.month, leap);

  always_comb begin
    res.mlen   = mlen;
    res.at_end = 1'b0;
    res.next   = cur;
    if (cur.day < mlen) begin
      res.next.day = cur.day + 5'd1;
    end else if (cur.month < gdad_pkg::MONTH_LAST) begin
      res.next.month = cur.month + 4'd1;
      res.next.day   = gdad_pkg::DAY_FIRST;
    end else if (cur.year < gdad_pkg::YEAR_TOP) begin
      res.next.year  = cur.year + 16'd1;
      res.next.month = gdad_pkg::MONTH_FIRST;
      res.next.day   = gdad_pkg::DAY_FIRST;
      if (cur.yr100 == gdad_pkg::CENTURY_LAST) begin
        res.next.yr100 = 7'd0;
        res.next.cent  = cur.cent + 2'd1;
      end else begin
        res.next.yr100 = cur.yr100 + 7'd1;
      end
    end else begin
      res.at_end = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gregorian_date_add_days.sv
// Gregorian date adder: checks a start date and advances it by a day count.
// An accepted word goes through the states that split the year, check the date,
// step one day at a time (stopping at the last day of year 65535) and load the
// output word; a new word is taken only once the sequencer is back in idle.
// rst_n is synchronous and active low; it clears the sequencer and output valid.
`default_nettype none

module gregorian_date_add_days (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // start_day[4:0], start_month[8:5], start_year[24:9], days_to_add[36:25], zeros
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // end_day[4:0], end_month[8:5], end_year[24:9], zeros
  output logic [31:0]      out_tdata,
  // date_valid[0], year_overflow[1]
  output logic [1:0]       out_tuser
);

  gdad_pkg::state_t state_r, state_nxt;
  gdad_pkg::date_t  date_r, date_nxt;
  logic [gdad_pkg::DAYS_BITS-1:0] cnt_r, cnt_nxt;
  logic valid_r, valid_nxt;
  logic ovf_r, ovf_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [31:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]  out_tuser_r, out_tuser_nxt;

  logic             in_acc;
  logic             split_done;
  gdad_pkg::split_t split_res;
  gdad_pkg::step_t  step_res;
  logic             start_ok;

  assign in_acc = in_tvalid && in_tready;

  gdad_ysplit u_ysplit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .year  (in_tdata[24:9]),
    .done  (split_done),
    .res   (split_res)
  );

  gdad_step u_step (
    .cur (date_r),
    .res (step_res)
  );

  assign start_ok = (date_r.month >= gdad_pkg::MONTH_FIRST) &&
                    (date_r.month <= gdad_pkg::MONTH_LAST) &&
                    (date_r.day >= gdad_pkg::DAY_FIRST) &&
                    (date_r.day <= step_res.mlen);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gdad_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    date_r      <= date_nxt;
    cnt_r       <= cnt_nxt;
    valid_r     <= valid_nxt;
    ovf_r       <= ovf_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    date_nxt       = date_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    ovf_nxt        = ovf_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    in_tready      = 1'b0;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      gdad_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          date_nxt.day   = in_tdata[4:0];
          date_nxt.month = in_tdata[8:5];
          date_nxt.year  = in_tdata[24:9];
          cnt_nxt        = gdad_pkg::DAYS_BITS'(in_tdata[36:25]);
          ovf_nxt        = 1'b0;
          state_nxt      = gdad_pkg::ST_SPLIT;
        end
      end
      gdad_pkg::ST_SPLIT: begin
        if (split_done) begin
          date_nxt.yr100 = split_res.yr100;
          date_nxt.cent  = split_res.cent;
          state_nxt      = gdad_pkg::ST_CHECK;
        end
      end
      gdad_pkg::ST_CHECK: begin
        valid_nxt = start_ok;
        if (start_ok && (cnt_r != '0)) begin
          state_nxt = gdad_pkg::ST_STEP;
        end else begin
          state_nxt = gdad_pkg::ST_DONE;
        end
      end
      gdad_pkg::ST_STEP: begin
        if (step_res.at_end) begin
          ovf_nxt   = 1'b1;
          state_nxt = gdad_pkg::ST_DONE;
        end else begin
          date_nxt = step_res.next;
          cnt_nxt  = cnt_r - 1'b1;
          if (cnt_r == gdad_pkg::DAYS_BITS'(1)) begin
            state_nxt = gdad_pkg::ST_DONE;
          end
        end
      end
      gdad_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {7'd0, date_r.year, date_r.month, date_r.day};
          out_tuser_nxt  = {ovf_r, valid_r};
          state_nxt      = gdad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gdad_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_accept_splits: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == gdad_pkg::ST_SPLIT))
    else $error("accepted word did not start the year split");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdad_pkg::ST_STEP) |-> (cnt_r != '0))
    else $error("stepping with no days left");

  a_ovf_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tuser[0])
    else $error("overflow reported for an invalid date");

  a_ovf_date: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == gdad_pkg::ST_DONE) && ovf_r) |->
      ((date_r.day == gdad_pkg::DAYS_LONG) && (date_r.month == gdad_pkg::MONTH_LAST) &&
       (date_r.year == gdad_pkg::YEAR_TOP)))
    else $error("saturated result is not the last day of the top year");

endmodule

`default_nettype wire
